// ----- hdl/sgsm_pkg.sv -----
package sgsm_pkg;

    localparam int VOCAB_DEF = 256;
    localparam int DIM_DEF   = 16;

    localparam logic [12:0] LOG2E_Q12    = 13'd5909;
    localparam logic [15:0] LN2_Q16      = 16'd45426;
    localparam logic [15:0] LOSS_AT_ZERO = 16'd42441;
    localparam logic [15:0] LR_RESET     = 16'd66;

    typedef enum logic [1:0] {
        OP_TRAIN,
        OP_WR_EMB,
        OP_WR_OW,
        OP_RD_EMB
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ_A,
        ST_READ_B,
        ST_CP_RD,
        ST_CP_WR,
        ST_SC_RD,
        ST_SC_ACC,
        ST_SC_WR,
        ST_EX_RD,
        ST_EX_MUL,
        ST_EX_WR,
        ST_PR_RD,
        ST_PR_LD,
        ST_PR_DIV,
        ST_PR_WR,
        ST_LS_INIT,
        ST_LS_SQ,
        ST_LS_FIN,
        ST_WU_PRD,
        ST_WU_ERR,
        ST_WU_RD,
        ST_WU_MUL,
        ST_WU_WR,
        ST_GR_RD,
        ST_GR_ACC,
        ST_GR_SUM,
        ST_GR_MUL,
        ST_GR_WR,
        ST_DONE
    } state_t;

    // 65536 * 2^(-i/16), i = 0..16
    function automatic logic [16:0] pow2_frac(input logic [4:0] idx);
        logic [16:0] v;
        unique case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/skipgram_softmax_train_step_unit.sv -----
// Skip-gram trainer with full softmax and SGD over on-chip embedding and
// output-weight tables (VOCAB rows of DIM signed Q3.12 elements each).
// Input channel s_*: one request per item; s_ready is high only while idle.
//   Table writes pass through ST_WRITE, and reads through ST_READ_A and
//   ST_READ_B to the result register. A train request runs a shared
//   multiply/accumulate, divide and log sequencer, whose run length is
//   set by the table memories' single read port and the bit-per-cycle
//   divider.
// Result channel m_*: one result per request (loss, read_value) held in an
//   output register; a new item may be taken while it waits. If the
//   receiver stalls, the next result waits in the sequencer until taken.
// Configuration: cfg_valid/cfg_ready write learning_rate, always ready;
//   write only while idle.
// Reset (aresetn low, synchronous): sequencer idle, result channel empty,
//   learning_rate = 66. Tables are not cleared and must be written first.
module skipgram_softmax_train_step_unit #(
    parameter int VOCAB = sgsm_pkg::VOCAB_DEF,
    parameter int DIM   = sgsm_pkg::DIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_learning_rate,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [7:0]         s_center_word,
    input  logic [7:0]         s_context_word,
    input  logic [3:0]         s_element_index,
    input  logic signed [15:0] s_weight_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_loss,
    output logic signed [15:0] m_read_value
);
    import sgsm_pkg::*;

    localparam int VW     = $clog2(VOCAB);
    localparam int DW     = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int DEPTH  = VOCAB * DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WX     = (VW > 8) ? VW : 8;
    localparam int EX     = (DW > 4) ? DW : 4;
    localparam int ACC_W  = 32 + DW + 1;
    localparam int SC_W   = ACC_W - 11;
    localparam int D_W    = SC_W + 1;
    localparam int Y_W    = D_W + 1;
    localparam int S_W    = 17 + VW;
    localparam int N_W    = ((S_W > 33) ? S_W : 33) + 1;
    localparam int GA_W   = 34 + VW + 1;

    // memories
    logic signed [15:0]     emb_mem [DEPTH];
    logic signed [15:0]     ow_mem [DEPTH];
    logic signed [SC_W-1:0] sc_mem [VOCAB];
    logic [15:0]            prob_mem [VOCAB];

    logic signed [15:0]     emb_rdata_reg, ow_rdata_reg;
    logic signed [SC_W-1:0] sc_rdata_reg;
    logic [15:0]            prob_rdata_reg;

    logic                   emb_we, ow_we, sc_we, prob_we;
    logic [ADDR_W-1:0]      emb_waddr, emb_raddr, ow_waddr, ow_raddr;
    logic signed [15:0]     emb_wdata, ow_wdata;
    logic [VW-1:0]          sc_waddr, sc_raddr, prob_waddr, prob_raddr;
    logic signed [SC_W-1:0] sc_wdata;
    logic [15:0]            prob_wdata;

    // control and datapath registers
    state_t                 state_reg, state_next;
    op_t                    op_reg;
    logic                   word_ok_reg, elem_ok_reg;
    logic [VW-1:0]          ctx_reg, i_reg;
    logic [DW-1:0]          j_reg, e_idx_reg;
    logic [ADDR_W-1:0]      row_base_reg, addr_reg;
    logic signed [15:0]     wval_reg;
    logic [15:0]            lr_reg;
    logic signed [15:0]     hc_reg [DIM];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SC_W-1:0] mx_reg;
    logic [Y_W-1:0]         y_reg;
    logic [S_W-1:0]         sum_reg, rem_reg;
    logic [N_W-1:0]         num_reg;
    logic [16:0]            q_reg;
    logic [5:0]             cnt_reg;
    logic [15:0]            pctx_reg, x_reg;
    logic [3:0]             m_reg;
    logic [10:0]            f_reg;
    logic signed [34:0]     le_reg;
    logic signed [50:0]     wp_reg;
    logic signed [15:0]     whold_reg;
    logic signed [GA_W-1:0] gacc_reg;
    logic signed [31:0]     g_reg;
    logic signed [48:0]     gp_reg;
    logic [15:0]            loss_reg;
    logic signed [15:0]     rv_reg;
    logic                   m_valid_reg;
    logic [15:0]            m_loss_reg;
    logic signed [15:0]     m_rv_reg;

    // combinational datapath
    logic [WX-1:0]          in_c_ext, in_x_ext;
    logic [EX-1:0]          in_e_ext;
    logic                   in_c_ok, in_x_ok, in_e_ok, accept, out_free;
    logic                   last_j, last_i, is_ctx;
    logic [ADDR_W-1:0]      elem_addr;
    logic signed [15:0]     hc_j;
    logic signed [31:0]     sc_prod;
    logic signed [ACC_W:0]  sc_rnd;
    logic signed [SC_W-1:0] score_val;
    logic signed [SC_W:0]   d_full;
    logic [D_W+12:0]        y_prod;
    logic                   ex_zero;
    logic [16:0]            ta, tb, tdiff, ex_v, ex_e;
    logic [24:0]            interp;
    logic [S_W:0]           rem_sh;
    logic                   div_ge;
    logic [15:0]            p_sat;
    logic [3:0]             m_find;
    logic [31:0]            sqr;
    logic [15:0]            n_val;
    logic [31:0]            lprod;
    logic signed [17:0]     err;
    logic signed [33:0]     gprod;
    logic signed [51:0]     wp_rnd;
    logic signed [15:0]     wnew;
    logic signed [GA_W:0]   g_rnd;
    logic signed [49:0]     gp_rnd;
    logic signed [15:0]     enew;

    assign in_c_ext = WX'(s_center_word);
    assign in_x_ext = WX'(s_context_word);
    assign in_e_ext = EX'(s_element_index);
    assign in_c_ok  = (32'(s_center_word) < 32'(VOCAB));
    assign in_x_ok  = (32'(s_context_word) < 32'(VOCAB));
    assign in_e_ok  = (32'(s_element_index) < 32'(DIM));
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign last_j    = (j_reg == DW'(DIM - 1));
    assign last_i    = (i_reg == VW'(VOCAB - 1));
    assign is_ctx    = (i_reg == ctx_reg);
    assign elem_addr = row_base_reg + ADDR_W'(e_idx_reg);
    assign hc_j      = hc_reg[j_reg];

    always_comb begin
        // scores
        sc_prod   = ow_rdata_reg * hc_j;
        sc_rnd    = $signed({acc_reg[ACC_W-1], acc_reg}) + (ACC_W + 1)'(2048);
        score_val = SC_W'(sc_rnd >>> 12);
        // exponent
        d_full  = $signed({mx_reg[SC_W-1], mx_reg}) - $signed({sc_rdata_reg[SC_W-1], sc_rdata_reg});
        y_prod  = (D_W + 13)'(D_W'(d_full)) * (D_W + 13)'(LOG2E_Q12);
        ex_zero = (y_reg >= Y_W'(24 * 4096));
        ta      = pow2_frac({1'b0, y_reg[11:8]});
        tb      = pow2_frac({1'b0, y_reg[11:8]} + 5'd1);
        tdiff   = ta - tb;
        interp  = (25'(tdiff) * 25'(y_reg[7:0]) + 25'd128) >> 8;
        ex_v    = ta - 17'(interp);
        ex_e    = ex_zero ? 17'd0 : (ex_v >> y_reg[16:12]);
        // divider step
        rem_sh  = {rem_reg, num_reg[N_W-1]};
        div_ge  = (rem_sh >= {1'b0, sum_reg});
        p_sat   = q_reg[16] ? 16'hFFFF : q_reg[15:0];
        // log
        m_find = 4'd0;
        for (int b = 0; b < 16; b++) begin
            if (pctx_reg[b]) begin
                m_find = 4'(b);
            end
        end
        sqr   = 32'(x_reg) * 32'(x_reg);
        n_val = {5'd16 - {1'b0, m_reg}, 11'd0} - {5'd0, f_reg};
        lprod = 32'(n_val) * 32'(LN2_Q16) + 32'd32768;
        // updates
        err    = $signed({2'b00, prob_rdata_reg}) - (is_ctx ? 18'sd65536 : 18'sd0);
        gprod  = err * ow_rdata_reg;
        wp_rnd = $signed({wp_reg[50], wp_reg}) + (52'sd1 <<< 31);
        wnew   = sat16(64'(whold_reg) - 64'(wp_rnd >>> 32));
        g_rnd  = $signed({gacc_reg[GA_W-1], gacc_reg}) + (GA_W + 1)'(2048);
        gp_rnd = $signed({gp_reg[48], gp_reg}) + (50'sd1 <<< 19);
        enew   = sat16(64'(hc_j) - 64'(gp_rnd >>> 20));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (op_t'(s_operation))
                        OP_TRAIN:  state_next = (in_c_ok && in_x_ok) ? ST_CP_RD : ST_DONE;
                        OP_WR_EMB: state_next = ST_WRITE;
                        OP_WR_OW:  state_next = ST_WRITE;
                        OP_RD_EMB: state_next = ST_READ_A;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_WRITE:   state_next = ST_DONE;
            ST_READ_A:  state_next = ST_READ_B;
            ST_READ_B:  state_next = ST_DONE;
            ST_CP_RD:   state_next = ST_CP_WR;
            ST_CP_WR:   state_next = last_j ? ST_SC_RD : ST_CP_RD;
            ST_SC_RD:   state_next = ST_SC_ACC;
            ST_SC_ACC:  state_next = last_j ? ST_SC_WR : ST_SC_RD;
            ST_SC_WR:   state_next = last_i ? ST_EX_RD : ST_SC_RD;
            ST_EX_RD:   state_next = ST_EX_MUL;
            ST_EX_MUL:  state_next = ST_EX_WR;
            ST_EX_WR:   state_next = last_i ? ST_PR_RD : ST_EX_RD;
            ST_PR_RD:   state_next = ST_PR_LD;
            ST_PR_LD:   state_next = ST_PR_DIV;
            ST_PR_DIV:  state_next = (cnt_reg == 6'(N_W - 1)) ? ST_PR_WR : ST_PR_DIV;
            ST_PR_WR:   state_next = last_i ? ST_LS_INIT : ST_PR_RD;
            ST_LS_INIT: state_next = (pctx_reg == 16'd0) ? ST_WU_PRD : ST_LS_SQ;
            ST_LS_SQ:   state_next = (cnt_reg == 6'd10) ? ST_LS_FIN : ST_LS_SQ;
            ST_LS_FIN:  state_next = ST_WU_PRD;
            ST_WU_PRD:  state_next = ST_WU_ERR;
            ST_WU_ERR:  state_next = ST_WU_RD;
            ST_WU_RD:   state_next = ST_WU_MUL;
            ST_WU_MUL:  state_next = ST_WU_WR;
            ST_WU_WR: begin
                if (!last_j) begin
                    state_next = ST_WU_RD;
                end else begin
                    state_next = last_i ? ST_GR_RD : ST_WU_PRD;
                end
            end
            ST_GR_RD:   state_next = ST_GR_ACC;
            ST_GR_ACC:  state_next = last_i ? ST_GR_SUM : ST_GR_RD;
            ST_GR_SUM:  state_next = ST_GR_MUL;
            ST_GR_MUL:  state_next = ST_GR_WR;
            ST_GR_WR:   state_next = last_j ? ST_DONE : ST_GR_RD;
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        emb_we     = 1'b0;
        emb_waddr  = elem_addr;
        emb_wdata  = wval_reg;
        emb_raddr  = addr_reg;
        ow_we      = 1'b0;
        ow_waddr   = elem_addr;
        ow_wdata   = wval_reg;
        ow_raddr   = addr_reg;
        sc_we      = 1'b0;
        sc_waddr   = i_reg;
        sc_wdata   = score_val;
        sc_raddr   = i_reg;
        prob_we    = 1'b0;
        prob_waddr = i_reg;
        prob_wdata = p_sat;
        prob_raddr = i_reg;
        unique case (state_reg)
            ST_WRITE: begin
                emb_we = (op_reg == OP_WR_EMB) && word_ok_reg && elem_ok_reg;
                ow_we  = (op_reg == OP_WR_OW) && word_ok_reg && elem_ok_reg;
            end
            ST_READ_A: emb_raddr = elem_addr;
            ST_SC_WR:  sc_we = 1'b1;
            ST_EX_WR: begin
                sc_we    = 1'b1;
                sc_wdata = SC_W'(ex_e);
            end
            ST_PR_WR:  prob_we = 1'b1;
            ST_WU_WR: begin
                ow_we    = 1'b1;
                ow_waddr = addr_reg;
                ow_wdata = wnew;
            end
            ST_GR_WR: begin
                emb_we    = 1'b1;
                emb_waddr = row_base_reg + ADDR_W'(j_reg);
                emb_wdata = enew;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (emb_we) begin
            emb_mem[emb_waddr] <= emb_wdata;
        end
        emb_rdata_reg <= emb_mem[emb_raddr];
        if (ow_we) begin
            ow_mem[ow_waddr] <= ow_wdata;
        end
        ow_rdata_reg <= ow_mem[ow_raddr];
        if (sc_we) begin
            sc_mem[sc_waddr] <= sc_wdata;
        end
        sc_rdata_reg <= sc_mem[sc_raddr];
        if (prob_we) begin
            prob_mem[prob_waddr] <= prob_wdata;
        end
        prob_rdata_reg <= prob_mem[prob_raddr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            lr_reg      <= LR_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                lr_reg <= cfg_learning_rate;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_reg       <= op_t'(s_operation);
                    word_ok_reg  <= in_c_ok && (op_t'(s_operation) != OP_TRAIN || in_x_ok);
                    elem_ok_reg  <= in_e_ok;
                    ctx_reg      <= in_x_ext[VW-1:0];
                    e_idx_reg    <= in_e_ext[DW-1:0];
                    wval_reg     <= s_weight_value;
                    row_base_reg <= ADDR_W'(int'(in_c_ext[VW-1:0]) * DIM);
                    addr_reg     <= ADDR_W'(int'(in_c_ext[VW-1:0]) * DIM);
                    j_reg        <= '0;
                    i_reg        <= '0;
                    acc_reg      <= '0;
                    loss_reg     <= '0;
                    rv_reg       <= '0;
                end
            end
            ST_READ_B: begin
                rv_reg <= (word_ok_reg && elem_ok_reg) ? emb_rdata_reg : 16'sd0;
            end
            ST_CP_WR: begin
                hc_reg[j_reg] <= emb_rdata_reg;
                if (last_j) begin
                    j_reg    <= '0;
                    addr_reg <= '0;
                end else begin
                    j_reg    <= j_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                end
            end
            ST_SC_ACC: begin
                acc_reg  <= acc_reg + ACC_W'(sc_prod);
                addr_reg <= addr_reg + 1'b1;
                j_reg    <= last_j ? '0 : j_reg + 1'b1;
            end
            ST_SC_WR: begin
                if (i_reg == '0 || score_val > mx_reg) begin
                    mx_reg <= score_val;
                end
                acc_reg <= '0;
                sum_reg <= '0;
                i_reg   <= last_i ? '0 : i_reg + 1'b1;
            end
            ST_EX_MUL: begin
                y_reg <= Y_W'(y_prod >> 12);
            end
            ST_EX_WR: begin
                sum_reg <= sum_reg + S_W'(ex_e);
                i_reg   <= last_i ? '0 : i_reg + 1'b1;
            end
            ST_PR_LD: begin
                num_reg <= N_W'({sc_rdata_reg[16:0], 16'd0}) + N_W'(sum_reg >> 1);
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            ST_PR_DIV: begin
                rem_reg <= div_ge ? S_W'(rem_sh - {1'b0, sum_reg}) : S_W'(rem_sh);
                q_reg   <= {q_reg[15:0], div_ge};
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_PR_WR: begin
                if (is_ctx) begin
                    pctx_reg <= p_sat;
                end
                i_reg <= last_i ? '0 : i_reg + 1'b1;
            end
            ST_LS_INIT: begin
                loss_reg <= LOSS_AT_ZERO;
                m_reg    <= m_find;
                x_reg    <= 16'(pctx_reg << (4'd15 - m_find));
                f_reg    <= '0;
                cnt_reg  <= '0;
                addr_reg <= '0;
                j_reg    <= '0;
            end
            ST_LS_SQ: begin
                if (sqr[31]) begin
                    x_reg <= sqr[31:16];
                    f_reg <= {f_reg[9:0], 1'b1};
                end else begin
                    x_reg <= sqr[30:15];
                    f_reg <= {f_reg[9:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_LS_FIN: begin
                loss_reg <= lprod[31:16];
            end
            ST_WU_ERR: begin
                le_reg <= $signed({1'b0, lr_reg}) * err;
            end
            ST_WU_MUL: begin
                wp_reg    <= le_reg * hc_j;
                whold_reg <= ow_rdata_reg;
            end
            ST_WU_WR: begin
                if (last_j) begin
                    j_reg <= '0;
                    if (last_i) begin
                        i_reg    <= '0;
                        addr_reg <= '0;
                        gacc_reg <= '0;
                    end else begin
                        i_reg    <= i_reg + 1'b1;
                        addr_reg <= addr_reg + 1'b1;
                    end
                end else begin
                    j_reg    <= j_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                end
            end
            ST_GR_ACC: begin
                gacc_reg <= gacc_reg + GA_W'(gprod);
                addr_reg <= addr_reg + ADDR_W'(DIM);
                i_reg    <= last_i ? '0 : i_reg + 1'b1;
            end
            ST_GR_SUM: begin
                g_reg <= sat32(64'(g_rnd >>> 12));
            end
            ST_GR_MUL: begin
                gp_reg <= $signed({1'b0, lr_reg}) * g_reg;
            end
            ST_GR_WR: begin
                gacc_reg <= '0;
                if (!last_j) begin
                    j_reg    <= j_reg + 1'b1;
                    addr_reg <= ADDR_W'(j_reg) + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_loss_reg <= loss_reg;
                    m_rv_reg   <= rv_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_loss       = m_loss_reg;
    assign m_read_value = m_rv_reg;

endmodule

// ----- tb/skipgram_softmax_train_step_unit_tb.sv -----
`timescale 1ns / 1ps

module skipgram_softmax_train_step_unit_tb;
    import sgsm_pkg::*;

    localparam int NWORDS    = 256;
    localparam int NDIM      = 16;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [15:0]        loss;
        logic signed [15:0] read_value;
    } result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_learning_rate = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation = '0;
    logic [7:0]         s_center_word = '0;
    logic [7:0]         s_context_word = '0;
    logic [3:0]         s_element_index = '0;
    logic signed [15:0] s_weight_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_loss;
    logic signed [15:0] m_read_value;

    skipgram_softmax_train_step_unit u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_learning_rate (cfg_learning_rate),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_center_word     (s_center_word),
        .s_context_word    (s_context_word),
        .s_element_index   (s_element_index),
        .s_weight_value    (s_weight_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_loss            (m_loss),
        .m_read_value      (m_read_value)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic signed [15:0] emb_tbl [0:NWORDS*NDIM-1];
    logic signed [15:0] ow_tbl  [0:NWORDS*NDIM-1];
    logic [15:0]        lr_q16 = LR_RESET;
    longint             score_q12 [0:NWORDS-1];
    longint             exp_q16v  [0:NWORDS-1];
    longint             prob_q16  [0:NWORDS-1];
    longint             grad_q16  [0:NDIM-1];
    longint             h_copy    [0:NDIM-1];
    longint             pow2_tab  [0:16] = '{65536, 62757, 60097, 57549, 55109, 52773,
        50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

    result_t pending_results [$];
    int      mismatches = 0;
    int      hold_cycles = 0;
    bit      random_ready = 1'b1;

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint exp_neg_q16(longint d);
        longint y, k, idx, r, a, b, v;
        y = (d * 5909) >>> 12;
        k = y >>> 12;
        if (k >= 24) return 0;
        idx = (y >>> 8) & 15;
        r = y & 255;
        a = pow2_tab[idx];
        b = pow2_tab[idx + 1];
        v = a - ((((a - b) * r) + 128) >>> 8);
        return v >>> k;
    endfunction

    function automatic logic [15:0] xent_q11(longint p);
        int     m;
        longint x, n, l;
        longint f;
        m = 0;
        f = 0;
        if (p == 0) return LOSS_AT_ZERO;
        for (int b = 0; b < 16; b++) if ((p >> b) & 1) m = b;
        x = p << (15 - m);
        for (int b = 0; b < 11; b++) begin
            x = (x * x) >> 15;
            f = f << 1;
            if (x >= 65536) begin
                f = f | 1;
                x = x >> 1;
            end
        end
        n = (longint'(16 - m) << 11) - f;
        l = (n * 45426 + 32768) >> 16;
        if (l > 65535) l = 65535;
        return l[15:0];
    endfunction

    function automatic logic [15:0] train_pair(int c, int ctx);
        longint acc, mx, total, q, err, delta;
        logic [15:0] loss;
        for (int j = 0; j < NDIM; j++) h_copy[j] = emb_tbl[c*NDIM + j];
        for (int i = 0; i < NWORDS; i++) begin
            acc = 0;
            for (int j = 0; j < NDIM; j++) acc += longint'(ow_tbl[i*NDIM + j]) * h_copy[j];
            score_q12[i] = (acc + 2048) >>> 12;
        end
        mx = score_q12[0];
        for (int i = 1; i < NWORDS; i++) if (score_q12[i] > mx) mx = score_q12[i];
        total = 0;
        for (int i = 0; i < NWORDS; i++) begin
            exp_q16v[i] = exp_neg_q16(mx - score_q12[i]);
            total += exp_q16v[i];
        end
        for (int i = 0; i < NWORDS; i++) begin
            q = (exp_q16v[i] * 65536 + total / 2) / total;
            prob_q16[i] = (q > 65535) ? 65535 : q;
        end
        loss = xent_q11(prob_q16[ctx]);
        for (int i = 0; i < NWORDS; i++) begin
            err = prob_q16[i] - ((i == ctx) ? 65536 : 0);
            for (int j = 0; j < NDIM; j++) begin
                delta = (longint'(lr_q16) * err * h_copy[j] + (64'sd1 << 31)) >>> 32;
                ow_tbl[i*NDIM + j] = clamp16(longint'(ow_tbl[i*NDIM + j]) - delta);
            end
        end
        for (int j = 0; j < NDIM; j++) begin
            acc = 0;
            for (int i = 0; i < NWORDS; i++) begin
                err = prob_q16[i] - ((i == ctx) ? 65536 : 0);
                acc += err * ow_tbl[i*NDIM + j];
            end
            grad_q16[j] = clamp32((acc + 2048) >>> 12);
        end
        for (int j = 0; j < NDIM; j++) begin
            delta = (longint'(lr_q16) * grad_q16[j] + (64'sd1 << 19)) >>> 20;
            emb_tbl[c*NDIM + j] = clamp16(longint'(emb_tbl[c*NDIM + j]) - delta);
        end
        return loss;
    endfunction

    function automatic result_t predict_request(op_t op, int c, int ctx, int e,
                                                logic signed [15:0] val);
        result_t r;
        r = '0;
        case (op)
            OP_TRAIN:  r.loss = train_pair(c, ctx);
            OP_WR_EMB: emb_tbl[c*NDIM + e] = val;
            OP_WR_OW:  ow_tbl[c*NDIM + e] = val;
            OP_RD_EMB: r.read_value = emb_tbl[c*NDIM + e];
            default:   r = '0;
        endcase
        return r;
    endfunction

    task automatic send_request(op_t op, int c, int ctx, int e, logic signed [15:0] val);
        result_t want;
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_center_word   <= c[7:0];
        s_context_word  <= ctx[7:0];
        s_element_index <= e[3:0];
        s_weight_value  <= val;
        do @(posedge aclk); while (!s_ready);
        want = predict_request(op, c, ctx, e, val);
        pending_results.insert(pending_results.size(), want);
    endtask

    task automatic sender_gap(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic wait_drained();
        if (s_valid) s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_lr(logic [15:0] v);
        wait_drained();
        cfg_valid         <= 1'b1;
        cfg_learning_rate <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lr_q16 = v;
    endtask

    task automatic test_table_init();
        for (int c = 0; c < NWORDS; c++) begin
            for (int e = 0; e < NDIM; e++) begin
                send_request(OP_WR_OW, c, 0, e, 16'(int'($urandom_range(1023)) - 512));
                send_request(OP_WR_EMB, c, 0, e, 16'(int'($urandom_range(8191)) - 4096));
                if ($urandom_range(15) == 0) sender_gap(random_gap());
            end
        end
    endtask

    task automatic test_directed();
        send_request(OP_WR_EMB, 0, 0, 0, 16'sh7FFF);
        send_request(OP_WR_EMB, 255, 0, 15, -16'sh8000);
        send_request(OP_WR_OW, 255, 0, 15, 16'sh7FFF);
        send_request(OP_WR_OW, 0, 0, 0, -16'sh8000);
        send_request(OP_RD_EMB, 0, 0, 0, '0);
        send_request(OP_RD_EMB, 255, 0, 15, '0);
        send_request(OP_TRAIN, 0, 255, 0, '0);
        send_request(OP_TRAIN, 255, 0, 0, '0);
        send_request(OP_TRAIN, 7, 7, 0, '0);
        send_request(OP_RD_EMB, 0, 0, 0, '0);
        send_request(OP_RD_EMB, 7, 0, 3, '0);
    endtask

    task automatic test_config_sweep();
        write_lr(16'd0);
        send_request(OP_TRAIN, 3, 200, 0, '0);
        send_request(OP_RD_EMB, 3, 0, 9, '0);
        write_lr(16'hFFFF);
        send_request(OP_TRAIN, 3, 12, 0, '0);
        send_request(OP_RD_EMB, 3, 0, 9, '0);
        write_lr(16'($urandom_range(4000, 100)));
    endtask

    task automatic test_backpressure();
        wait_drained();
        @(negedge aclk);
        hold_cycles = 400;
        @(posedge aclk);
        for (int i = 0; i < 12; i++)
            send_request(op_t'($urandom_range(3, 1)), $urandom_range(255), 0,
                         $urandom_range(15), 16'($urandom));
        wait_drained();
    endtask

    task automatic test_random();
        op_t op;
        for (int i = 0; i < 100; i++) begin
            op = ($urandom_range(99) < 10) ? OP_TRAIN : op_t'($urandom_range(3, 1));
            send_request(op, $urandom_range(255), $urandom_range(255),
                         $urandom_range(15), 16'($urandom));
            if ($urandom_range(3) != 0) sender_gap(random_gap());
            if (i == 50) write_lr(16'($urandom));
        end
        sender_gap(0);
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (random_ready) begin
            m_ready <= ($urandom_range(9) < 7) || ($urandom_range(99) < 20);
            if ($urandom_range(199) == 0) hold_cycles <= $urandom_range(80, 20);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result loss=%0d read_value=%0d", m_loss, m_read_value);
            end else begin
                want = pending_results.pop_front();
                if (m_loss !== want.loss || m_read_value !== want.read_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: loss exp %0d got %0d, read_value exp %0d got %0d",
                                 want.loss, m_loss, want.read_value, m_read_value);
                end
            end
        end
    end

    int idle_count = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NWORDS*NDIM; i++) begin
            emb_tbl[i] = '0;
            ow_tbl[i]  = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_init();
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
